@@ src/dcf_pkg.sv @@
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, constants and the double-dabble step for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int BIN_W     = 32;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = DIGITS * 4;
  localparam int STEP_BITS = 8;
  localparam int STAGES    = BIN_W / STEP_BITS;
  localparam int DIG_IW    = $clog2(DIGITS);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;

  typedef struct packed {
    logic [31:0] value;
    logic        add_line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
    logic             line_end;
  } work_t;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_DIGIT,
    SER_CR,
    SER_LF
  } ser_state_t;

  // Shift STEP_BITS binary bits into the BCD field, add-3 correction first.
  function automatic work_t dd_step(input work_t w);
    work_t r;
    r = w;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (r.bcd[d*4 +: 4] >= 4'd5) begin
          r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[BIN_W-1]};
      r.bin = {r.bin[BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ src/dcf_dd_stage.sv @@
// ----------------------------------------------------------------------------
// dcf_dd_stage
// One pipeline stage of the binary to BCD conversion (STEP_BITS bits).
// ----------------------------------------------------------------------------
module dcf_dd_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  dcf_pkg::work_t up_work,
  output logic           up_ready,
  output logic           dn_valid,
  output dcf_pkg::work_t dn_work,
  input  logic           dn_ready
);

  logic           valid_r;
  dcf_pkg::work_t work_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_work  = work_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work_r <= dcf_pkg::dd_step(up_work);
    end
  end

endmodule

@@ src/dcf_serializer.sv @@
// ----------------------------------------------------------------------------
// dcf_serializer
// Sends the significant BCD digits as ASCII, then optional CR LF.
// ----------------------------------------------------------------------------
module dcf_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  dcf_pkg::work_t up_work,
  output logic           up_ready,
  output logic           out_valid,
  output dcf_pkg::out_t  out_item,
  input  logic           out_stall
);

  dcf_pkg::ser_state_t           state_r, state_nxt;
  logic [dcf_pkg::BCD_W-1:0]     bcd_r;
  logic                          le_r;
  logic [dcf_pkg::DIG_IW-1:0]    pos_r, pos_nxt;
  logic [dcf_pkg::DIG_IW-1:0]    msd;
  logic                          out_valid_r;
  dcf_pkg::out_t                 out_item_r;
  logic                          out_free;
  logic                          emit;
  dcf_pkg::out_t                 byte_cur;
  logic                          take;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r != dcf_pkg::SER_IDLE) && out_free;
  assign up_ready  = (state_r == dcf_pkg::SER_IDLE) || (emit && byte_cur.last_char);
  assign take      = up_ready && up_valid;

  always_comb begin
    msd = '0;
    for (int d = 1; d < dcf_pkg::DIGITS; d++) begin
      if (up_work.bcd[d*4 +: 4] != 4'd0) begin
        msd = dcf_pkg::DIG_IW'(d);
      end
    end
  end

  always_comb begin
    byte_cur = '0;
    case (state_r)
      dcf_pkg::SER_DIGIT: begin
        byte_cur.out_char  = dcf_pkg::CHAR_ZERO + {4'd0, bcd_r[pos_r*4 +: 4]};
        byte_cur.last_char = (pos_r == '0) && !le_r;
      end
      dcf_pkg::SER_CR: begin
        byte_cur.out_char = dcf_pkg::CHAR_CR;
      end
      dcf_pkg::SER_LF: begin
        byte_cur.out_char  = dcf_pkg::CHAR_LF;
        byte_cur.last_char = 1'b1;
      end
      default: begin
        byte_cur = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (emit) begin
      case (state_r)
        dcf_pkg::SER_DIGIT: begin
          if (pos_r != '0) begin
            pos_nxt = pos_r - 1'b1;
          end else if (le_r) begin
            state_nxt = dcf_pkg::SER_CR;
          end else begin
            state_nxt = dcf_pkg::SER_IDLE;
          end
        end
        dcf_pkg::SER_CR: state_nxt = dcf_pkg::SER_LF;
        dcf_pkg::SER_LF: state_nxt = dcf_pkg::SER_IDLE;
        default:         state_nxt = dcf_pkg::SER_IDLE;
      endcase
    end
    if (take) begin
      state_nxt = dcf_pkg::SER_DIGIT;
      pos_nxt   = msd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcf_pkg::SER_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (take) begin
      bcd_r <= up_work.bcd;
      le_r  <= up_work.line_end;
    end
    if (emit) begin
      out_item_r <= byte_cur;
    end
  end

endmodule

@@ src/decimal_ascii_formatter.sv @@
// Path: an item passes the 4 conversion stages (the first loaded at the accepting
// edge), then the serializer load and the output register before its first byte.
// Throughput: one byte per cycle while out_stall is low; an item yields 1 to 12
// bytes (digit count, plus 2 with line end). The pipeline holds 4 more items.
// Reset (rst_n low, synchronous) clears all valid bits and the serializer.
// ----------------------------------------------------------------------------
// decimal_ascii_formatter
// Unsigned 32-bit to decimal ASCII, no leading zeros, optional CR LF.
// ----------------------------------------------------------------------------
module decimal_ascii_formatter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  dcf_pkg::in_t  in_item,
  output logic          in_stall,
  output logic          out_valid,
  output dcf_pkg::out_t out_item,
  input  logic          out_stall
);

  logic           vld [dcf_pkg::STAGES+1];
  logic           rdy [dcf_pkg::STAGES+1];
  dcf_pkg::work_t wrk [dcf_pkg::STAGES+1];

  assign vld[0]      = in_valid;
  assign wrk[0].bcd  = '0;
  assign wrk[0].bin  = in_item.value;
  assign wrk[0].line_end = in_item.add_line_end;
  assign in_stall    = !rdy[0];

  for (genvar g = 0; g < dcf_pkg::STAGES; g++) begin : g_stage
    dcf_dd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_work  (wrk[g]),
      .up_ready (rdy[g]),
      .dn_valid (vld[g+1]),
      .dn_work  (wrk[g+1]),
      .dn_ready (rdy[g+1])
    );
  end

  dcf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld[dcf_pkg::STAGES]),
    .up_work   (wrk[dcf_pkg::STAGES]),
    .up_ready  (rdy[dcf_pkg::STAGES]),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
